// ===== sv/adeq_pkg.sv =====
// ----------------------------------------------------------------------------
// adeq_pkg
// Shared types and constants for the array double-ended queue.
// ----------------------------------------------------------------------------
package adeq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFRONT = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;    // request taken this cycle
        logic load_pop;  // move read data into the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;   // current request is a pop of a non-empty queue
    } t_dp_sts;

endpackage

// ===== sv/adeq_ifs.sv =====
// ----------------------------------------------------------------------------
// adeq request and response channels
// Valid/ready channels carrying one queue request or one result.
// ----------------------------------------------------------------------------
interface adeq_req_if
    import adeq_pkg::*;
();
    logic               valid;
    logic               ready;
    t_opcode            opcode;
    logic signed [31:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface adeq_rsp_if
    import adeq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [31:0] pop_value;
    t_status            status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// ===== sv/adeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// adeq_ctrl
// Sequencer: takes requests, waits in S_POP on the registered memory read for
// pops and owns the result valid flag.
// ----------------------------------------------------------------------------
module adeq_ctrl
    import adeq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   req_ready;
    logic   accept;

    // a request may enter in S_IDLE when the result register is free or drains now
    assign req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign accept    = i_req_valid && req_ready;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.pop_hit) begin
                        n_state = S_POP;
                    end else begin
                        n_rsp_valid = 1'b1;
                    end
                end
            end
            S_POP: begin
                n_state     = S_IDLE;
                n_rsp_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready    = req_ready;
    assign o_rsp_valid    = r_rsp_valid;
    assign o_cmd.accept   = accept;
    assign o_cmd.load_pop = (r_state == S_POP);

endmodule

// ===== sv/adeq_dp.sv =====
// ----------------------------------------------------------------------------
// adeq_dp
// Datapath: slot memory, head and tail indices, result register.
// ----------------------------------------------------------------------------
module adeq_dp
    import adeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  t_opcode            i_opcode,
    input  logic signed [31:0] i_push_value,
    output logic signed [31:0] o_pop_value,
    output t_status            o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);

    logic [VAL_W-1:0]        r_mem [DEPTH];
    logic [VAL_W-1:0]        r_rd_data;
    logic [IW-1:0]           r_head, n_head;
    logic [IW-1:0]           r_tail, n_tail;
    logic signed [VAL_W-1:0] r_pop_value;
    t_status                 r_status;

    logic                    empty;
    logic                    no_front;
    logic                    full;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    t_status                 op_status;
    logic                    pop_hit;

    assign empty    = (r_head == r_tail);
    assign no_front = (r_head == '0);
    assign full     = (r_tail == IW'(DEPTH));

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        wr_en     = 1'b0;
        op_status = ST_OK;
        pop_hit   = 1'b0;
        unique case (i_opcode)
            OP_PUSH_FRONT: begin
                if (no_front) begin
                    op_status = ST_NOFRONT;
                end else begin
                    n_head = r_head - IW'(1);
                    wr_en  = 1'b1;
                end
            end
            OP_PUSH_REAR: begin
                if (full) begin
                    op_status = ST_FULL;
                end else begin
                    n_tail = r_tail + IW'(1);
                    wr_en  = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    n_head  = r_head + IW'(1);
                    pop_hit = 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    n_tail  = r_tail - IW'(1);
                    pop_hit = 1'b1;
                end
            end
            default: begin
                op_status = ST_OK;
            end
        endcase
    end

    // front push writes below the old head, rear pop reads below the old tail
    assign wr_addr = (i_opcode == OP_PUSH_FRONT) ? n_head[AW-1:0] : r_tail[AW-1:0];
    assign rd_addr = (i_opcode == OP_POP_FRONT) ? r_head[AW-1:0] : n_tail[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[wr_addr] <= i_push_value;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pop) begin
            r_pop_value <= r_rd_data;
            r_status    <= ST_OK;
        end else if (i_cmd.accept && !pop_hit) begin
            r_pop_value <= (op_status == ST_EMPTY) ? '1 : '0;
            r_status    <= op_status;
        end
    end

    assign o_sts.pop_hit = pop_hit;
    assign o_pop_value   = r_pop_value;
    assign o_status      = r_status;

endmodule

// ===== sv/array_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// array_double_ended_queue
// Non-wrapping double-ended queue over a fixed slot memory.
//
//   channel   dir  fields                          handshake
//   i_req     in   opcode[1:0], push_value[31:0]   valid/ready
//   o_rsp     out  pop_value[31:0], status[1:0]    valid/ready
//
// Pushes and failed pops give their result in the cycle after acceptance.
// Successful pops pass through S_POP first: the slot memory read port is registered.
// A new request is taken while the controller is idle and the result register is empty or being drained.
// Reset (synchronous, active low) clears head, tail and the result valid flag.
// A stalled result holds the request channel off until it is taken.
// ----------------------------------------------------------------------------
module array_double_ended_queue
    import adeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adeq_req_if.sink    i_req,
    adeq_rsp_if.source  o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    req_ready;
    logic    rsp_valid;

    adeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    adeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_req.opcode),
        .i_push_value (i_req.push_value),
        .o_pop_value  (o_rsp.pop_value),
        .o_status     (o_rsp.status)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

    // a successful pop shows its result only after the S_POP state has loaded the read data
    a_pop_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.pop_hit) |=> !o_rsp.valid ##1 o_rsp.valid)
        else $error("pop result timing broken");

    // nothing enters while a result is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !cmd.accept)
        else $error("request accepted over a stalled result");

    // an empty report always carries the all-ones value
    a_empty_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |-> (o_rsp.pop_value == -32'sd1))
        else $error("empty result without all-ones value");

    // the datapath never loads a pop result while a new request is taken
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_pop |-> !cmd.accept)
        else $error("pop load overlaps acceptance");

endmodule

// ===== verif/adeq_queue_checker.sv =====
// ----------------------------------------------------------------------------
// adeq_queue_checker
// Watches the request and result channels of the double-ended queue. It keeps
// its own copy of the slot memory and the head and tail indices, works out the
// result of every accepted request and compares it with each returned item.
// ----------------------------------------------------------------------------
module adeq_queue_checker
    import adeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    adeq_req_if        i_req,
    adeq_rsp_if        i_rsp,
    output int         o_error_count,
    output int         o_outstanding,
    output int         o_status_seen [4]
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] pop_value;
        t_status            status;
    } t_queue_result;

    logic signed [31:0] slot_mem [DEPTH];
    logic [IDX_W-1:0]   head_idx;
    logic [IDX_W-1:0]   tail_idx;
    t_queue_result      expected_results [$];
    int                 errors;
    int                 status_hits [4];

    // applies one request to the shadow queue and returns its result
    function automatic t_queue_result apply_queue_op(t_opcode op, logic signed [31:0] value);
        t_queue_result r;
        r.pop_value = '0;
        r.status    = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (head_idx == 0) begin
                    r.status = ST_NOFRONT;
                end else begin
                    head_idx           = head_idx - 1'b1;
                    slot_mem[head_idx] = value;
                end
            end
            OP_PUSH_REAR: begin
                if (tail_idx >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_mem[tail_idx] = value;
                    tail_idx           = tail_idx + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (head_idx == tail_idx) begin
                    r.status    = ST_EMPTY;
                    r.pop_value = -32'sd1;
                end else begin
                    r.pop_value = slot_mem[head_idx];
                    head_idx    = head_idx + 1'b1;
                end
            end
            default: begin
                if (head_idx == tail_idx) begin
                    r.status    = ST_EMPTY;
                    r.pop_value = -32'sd1;
                end else begin
                    tail_idx    = tail_idx - 1'b1;
                    r.pop_value = slot_mem[tail_idx];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_result want;
        if (!i_rst_n) begin
            head_idx = '0;
            tail_idx = '0;
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(apply_queue_op(i_req.opcode, i_req.push_value));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result item: pop_value %0d status %0d",
                             $time, i_rsp.pop_value, i_rsp.status);
                end else begin
                    want = expected_results.pop_front();
                    status_hits[want.status]++;
                    if (i_rsp.pop_value !== want.pop_value) begin
                        errors++;
                        $display("%0t: pop_value mismatch: expected %0d got %0d",
                                 $time, want.pop_value, i_rsp.pop_value);
                    end
                    if (i_rsp.status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d got %0d",
                                 $time, want.status, i_rsp.status);
                    end
                end
            end
        end
        o_outstanding <= expected_results.size();
        o_error_count <= errors;
        for (int s = 0; s < 4; s++) begin
            o_status_seen[s] <= status_hits[s];
        end
    end

endmodule

// ===== verif/tb_array_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// tb_array_double_ended_queue
// Drives directed and random queue requests with bursty valid and a stalling
// result ready; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_array_double_ended_queue;
    import adeq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RANDOM_REQS = 650;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int error_count;
    int outstanding;
    int status_seen [4];
    int reqs_sent;
    int burst_left;
    int bias_left;
    int gap;
    int ready_mode;
    int mode_left;
    int stall_left;
    t_opcode bias_op;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    adeq_req_if req_if ();
    adeq_rsp_if rsp_if ();

    array_double_ended_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    adeq_queue_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_error_count(error_count),
        .o_outstanding(outstanding),
        .o_status_seen(status_seen)
    );

    task automatic send_request(t_opcode op, logic signed [31:0] value);
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.push_value <= value;
        do @(posedge i_clk); while (!req_if.ready);
        reqs_sent++;
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // result ready: always on, coin flips, or runs of stalls
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                    if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
                end
            end
        endcase
    end

    initial begin
        #(2_000_000);
        $display("FAIL array_double_ended_queue");
        $finish;
    end

    initial begin
        req_if.valid      <= 1'b0;
        req_if.opcode     <= OP_PUSH_FRONT;
        req_if.push_value <= '0;
        i_rst_n           <= 1'b0;
        reqs_sent  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pops from both ends, front push with no room below head
        send_request(OP_POP_FRONT, 32'sh7fff_ffff);
        send_request(OP_POP_REAR, 32'sh8000_0000);
        send_request(OP_PUSH_FRONT, 32'sh7fff_ffff);
        // fill from the rear to the end of the array, then one more
        send_request(OP_PUSH_REAR, 32'sh8000_0000);
        send_request(OP_PUSH_REAR, 32'sh7fff_ffff);
        send_request(OP_PUSH_REAR, -32'sd1);
        send_request(OP_PUSH_REAR, 32'sd0);
        send_request(OP_PUSH_REAR, 32'sh5555_5555);
        send_request(OP_PUSH_REAR, 32'shaaaa_aaaa);
        for (int k = 6; k < DEPTH; k++) send_request(OP_PUSH_REAR, $urandom);
        send_request(OP_PUSH_REAR, 32'sd1);
        // free one slot at the front, refill it, then hit the bottom again
        send_request(OP_POP_FRONT, 32'sd0);
        send_request(OP_PUSH_FRONT, 32'sh0000_1234);
        send_request(OP_PUSH_FRONT, -32'sd2);
        send_request(OP_POP_REAR, -32'sd1);
        drain_results();

        burst_left = $urandom_range(1, 24);
        bias_left  = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            // each phase favors one operation so the queue walks to its limits
            if (bias_left == 0) begin
                bias_op   = t_opcode'($urandom_range(0, 3));
                bias_left = $urandom_range(8, 40);
            end
            bias_left--;
            if ($urandom_range(0, 99) < 65) begin
                send_request(bias_op, pick_value());
            end else begin
                send_request(t_opcode'($urandom_range(0, 3)), pick_value());
            end
            if (n == RANDOM_REQS / 2) begin
                drain_results();
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 6);
                    if (gap > 0) begin
                        req_if.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("covered %0d requests, bursty sender and stalling receiver", reqs_sent);
        $display("results: %0d ok, %0d no room at front, %0d full at rear, %0d empty",
                 status_seen[ST_OK], status_seen[ST_NOFRONT], status_seen[ST_FULL],
                 status_seen[ST_EMPTY]);
        if (error_count == 0 && outstanding == 0) begin
            $display("PASS array_double_ended_queue");
        end else begin
            $display("FAIL array_double_ended_queue");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/adeq_pkg.sv
sv/adeq_ifs.sv
sv/adeq_ctrl.sv
sv/adeq_dp.sv
sv/array_double_ended_queue.sv
verif/adeq_queue_checker.sv
verif/tb_array_double_ended_queue.sv
